>>> design/rnl_pkg.sv
// Shared types and character constants for the real number lexer with letter echo.
package rnl_pkg;

	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_BRACKET = 8'h5b;
	localparam logic [7:0] CH_HOME    = 8'h48;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_LC_Z    = 8'h7a;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_UC_Z    = 8'h5a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_POINT   = 8'h2e;
	localparam logic [7:0] CH_EXP     = 8'h65;

	typedef struct packed {
		logic       mirror_valid;
		logic [7:0] mirror_char;
		logic       number_ok;
		logic       halted;
	} res_t;

	localparam res_t RES_HALTED = '{mirror_valid: 1'b0, mirror_char: 8'h00,
		number_ok: 1'b0, halted: 1'b1};

	// Atbash within each case; other bytes give valid 0 and char 0.
	function automatic logic [8:0] atbash(input logic [7:0] c);
		logic [8:0] r;
		r = '0;
		if (c >= CH_LC_A && c <= CH_LC_Z) begin
			r = {1'b1, 8'(CH_LC_Z + CH_LC_A - c)};
		end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
			r = {1'b1, 8'(CH_UC_Z + CH_UC_A - c)};
		end
		return r;
	endfunction

endpackage

>>> design/rnl_in_if.sv
// Input channel: one key byte per transfer.
interface rnl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink   (input valid, input key_byte, output ready);
endinterface

>>> design/rnl_out_if.sv
// Output channel: one echo and status result per transfer.
interface rnl_out_if;
	logic       valid;
	logic       ready;
	logic       mirror_valid;
	logic [7:0] mirror_char;
	logic       number_ok;
	logic       halted;

	modport source (output valid, output mirror_valid, output mirror_char,
		output number_ok, output halted, input ready);
	modport sink   (input valid, input mirror_valid, input mirror_char,
		input number_ok, input halted, output ready);
endinterface

>>> design/rnl_in_stage.sv
// Input register stage holding one accepted key byte.
module rnl_in_stage
	import rnl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] key_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= in_byte;
		end
	end

endmodule

>>> design/rnl_core.sv
// Lexer state machine, control capture and letter mirror for one byte per cycle while step is high.
module rnl_core
	import rnl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] key,
	output res_t       res
);

	typedef enum logic [2:0] {
		M_BEFORE = 3'd0,
		M_INT    = 3'd1,
		M_FRAC   = 3'd2,
		M_DOT    = 3'd3,
		M_E      = 3'd4,
		M_EXP    = 3'd5,
		M_CTRL   = 3'd6
	} mode_t;

	mode_t      mode_q, mode_n, saved_q, saved_n;
	logic       cnt_q, cnt_n;
	logic [7:0] first_q, first_n;
	logic       ok_q, ok_n;
	logic       stop_q, stop_n;
	logic       dg, sign, pt, ex;
	logic [8:0] mir;

	assign dg   = key >= CH_ZERO && key <= CH_NINE;
	assign sign = key == CH_MINUS || key == CH_PLUS;
	assign pt   = key == CH_POINT;
	assign ex   = key == CH_EXP;
	assign mir  = atbash(key);

	always_comb begin
		mode_n  = mode_q;
		saved_n = saved_q;
		cnt_n   = cnt_q;
		first_n = first_q;
		ok_n    = ok_q;
		stop_n  = stop_q;
		if (!stop_q) begin
			if (key == CH_ESC) begin
				cnt_n   = 1'b0;
				saved_n = mode_q;
				mode_n  = M_CTRL;
			end else if (mode_q == M_CTRL) begin
				if (!cnt_q) begin
					first_n = key;
					cnt_n   = 1'b1;
				end else begin
					mode_n = saved_q;
					if (first_q == CH_BRACKET && key == CH_HOME) begin
						stop_n = 1'b1;
					end
				end
			end else begin
				if (!(dg || sign || pt || ex)) begin
					ok_n = 1'b0;
				end
				unique case (mode_q)
					M_BEFORE: begin
						if (dg || sign) mode_n = M_INT;
						else ok_n = 1'b0;
					end
					M_INT: begin
						// a minus sign ends validity here, a plus does not
						if (!(dg || pt || ex || key == CH_PLUS)) ok_n = 1'b0;
						if (pt) mode_n = M_DOT;
						else if (ex) mode_n = M_E;
					end
					M_DOT: begin
						if (!dg) ok_n = 1'b0;
						mode_n = M_FRAC;
					end
					M_FRAC: begin
						if (!(dg || ex)) ok_n = 1'b0;
						if (ex) mode_n = M_E;
					end
					M_E: begin
						if (!(dg || sign)) ok_n = 1'b0;
						mode_n = M_EXP;
					end
					M_EXP: begin
						if (!dg) ok_n = 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		if (stop_n) begin
			res = RES_HALTED;
		end else if (key != CH_ESC && mode_q != M_CTRL) begin
			res = '{mirror_valid: mir[8], mirror_char: mir[7:0], number_ok: ok_n,
				halted: 1'b0};
		end else begin
			res = '{mirror_valid: 1'b0, mirror_char: 8'h00, number_ok: ok_n,
				halted: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BEFORE;
			saved_q <= M_BEFORE;
			cnt_q   <= 1'b0;
			first_q <= 8'h00;
			ok_q    <= 1'b1;
			stop_q  <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			saved_q <= saved_n;
			cnt_q   <= cnt_n;
			first_q <= first_n;
			ok_q    <= ok_n;
			stop_q  <= stop_n;
		end
	end

endmodule

>>> design/rnl_out_stage.sv
// Result register stage feeding the output channel.
module rnl_out_stage
	import rnl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	input  logic out_ready,
	output logic advance,
	output logic valid_s2,
	output res_t res_s2
);

	assign advance = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_s2 <= res;
		end
	end

endmodule

>>> design/real_number_lexer_with_atbash_echo.sv
// The input register holds an accepted byte and the result register its result for the
// output channel. Throughput: one byte per cycle while the output is not held back;
// lexer state updates as an item moves to the result register.
// The result register lets a new byte enter while a finished result waits.
// Reset (arst_n low, asynchronous): both stages empty, lexer before entering,
// number flag set, not halted.
module real_number_lexer_with_atbash_echo
	import rnl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	rnl_in_if.sink    in,
	rnl_out_if.source out
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] key_s1;
	logic       valid_s2;
	logic       step;
	res_t       res;
	res_t       res_s2;

	assign step = valid_s1 && advance;

	rnl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.in_byte  (in.key_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.key_s1   (key_s1)
	);

	rnl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.key    (key_s1),
		.res    (res)
	);

	rnl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res       (res),
		.out_ready (out.ready),
		.advance   (advance),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2)
	);

	assign out.valid        = valid_s2;
	assign out.mirror_valid = res_s2.mirror_valid;
	assign out.mirror_char  = res_s2.mirror_char;
	assign out.number_ok    = res_s2.number_ok;
	assign out.halted       = res_s2.halted;

endmodule

>>> design/rnl_checker.sv
// Port-level checks on the result stream, bound to the top level.
module rnl_checker
	import rnl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_mirror_valid,
	input logic [7:0] out_mirror_char,
	input logic       out_number_ok,
	input logic       out_halted
);

	logic halt_seen_q;
	logic bad_seen_q;
	logic xfer;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_seen_q <= 1'b0;
			bad_seen_q  <= 1'b0;
		end else if (xfer) begin
			if (out_halted) halt_seen_q <= 1'b1;
			if (!out_number_ok) bad_seen_q <= 1'b1;
		end
	end

	// halt is permanent
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halt_seen_q |-> out_halted)
		else $error("result after halt not halted");

	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_halted |-> !out_mirror_valid && out_mirror_char == 8'h00
			&& !out_number_ok)
		else $error("halted result carries data");

	a_ok_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_seen_q |-> !out_number_ok)
		else $error("number flag set again");

	a_no_echo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_mirror_valid |-> out_mirror_char == 8'h00)
		else $error("char without valid echo");

	a_echo_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mirror_valid |->
			(out_mirror_char >= CH_LC_A && out_mirror_char <= CH_LC_Z) ||
			(out_mirror_char >= CH_UC_A && out_mirror_char <= CH_UC_Z))
		else $error("echo is not a letter");

endmodule

bind real_number_lexer_with_atbash_echo rnl_checker u_rnl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.out_mirror_valid (out.mirror_valid),
	.out_mirror_char  (out.mirror_char),
	.out_number_ok    (out.number_ok),
	.out_halted       (out.halted)
);

>>> bench/rnl_result_checker.sv
`timescale 1ns / 100ps
// Result checker: predicts the lexer and letter echo per key byte and compares each result.
module rnl_result_checker
	import rnl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rnl_in_if    in_ch,
	rnl_out_if   out_ch,
	output int   mismatches,
	output int   outstanding
);

	typedef enum logic [2:0] {
		LX_BEFORE, LX_INT, LX_FRAC, LX_DOT, LX_EXP_MARK, LX_EXP, LX_CTRL
	} lex_mode_t;

	lex_mode_t  mode;
	lex_mode_t  mode_saved;
	logic       cap_second;
	logic [7:0] cap_first;
	logic       num_ok;
	logic       stop;
	res_t       expected_results[$];

	function automatic logic is_dec(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Advances the predicted lexer by one byte and returns the result it causes.
	function automatic res_t lex_and_mirror(input logic [7:0] c);
		res_t r;
		logic dg;
		logic numeric;
		r = '0;
		if (stop) return RES_HALTED;
		dg = is_dec(c);
		numeric = dg || c == CH_MINUS || c == CH_POINT || c == CH_EXP || c == CH_PLUS;
		if (c == CH_ESC) begin
			cap_second = 1'b0;
			mode_saved = mode;
			mode = LX_CTRL;
		end else if (mode == LX_CTRL) begin
			if (!cap_second) begin
				cap_first = c;
				cap_second = 1'b1;
			end else begin
				// saved mode may itself be control after a nested escape
				mode = mode_saved;
				if (cap_first == CH_BRACKET && c == CH_HOME) stop = 1'b1;
			end
		end else begin
			if (c >= CH_LC_A && c <= CH_LC_Z) begin
				r.mirror_valid = 1'b1;
				r.mirror_char = CH_LC_A + (CH_LC_Z - c);
			end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
				r.mirror_valid = 1'b1;
				r.mirror_char = CH_UC_A + (CH_UC_Z - c);
			end
			if (!numeric) num_ok = 1'b0;
			case (mode)
				LX_BEFORE: begin
					if (dg || c == CH_MINUS || c == CH_PLUS) mode = LX_INT;
					else num_ok = 1'b0;
				end
				LX_INT: begin
					if (!(dg || c == CH_POINT || c == CH_EXP || c == CH_PLUS)) num_ok = 1'b0;
					if (c == CH_POINT) mode = LX_DOT;
					else if (c == CH_EXP) mode = LX_EXP_MARK;
				end
				LX_DOT: begin
					if (!dg) num_ok = 1'b0;
					mode = LX_FRAC;
				end
				LX_FRAC: begin
					if (!(dg || c == CH_EXP)) num_ok = 1'b0;
					if (c == CH_EXP) mode = LX_EXP_MARK;
				end
				LX_EXP_MARK: begin
					if (!(dg || c == CH_MINUS || c == CH_PLUS)) num_ok = 1'b0;
					mode = LX_EXP;
				end
				LX_EXP: begin
					if (!dg) num_ok = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (stop) return RES_HALTED;
		r.number_ok = num_ok;
		r.halted = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_res;
		if (!arst_n) begin
			mode = LX_BEFORE;
			mode_saved = LX_BEFORE;
			cap_second = 1'b0;
			cap_first = '0;
			num_ok = 1'b1;
			stop = 1'b0;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected",
						{out_ch.mirror_valid, out_ch.mirror_char, out_ch.number_ok,
						out_ch.halted}, 0);
				end else begin
					exp_res = expected_results.pop_front();
					if (out_ch.mirror_valid !== exp_res.mirror_valid)
						report_mismatch("mirror_valid", out_ch.mirror_valid, exp_res.mirror_valid);
					if (out_ch.mirror_char !== exp_res.mirror_char)
						report_mismatch("mirror_char", out_ch.mirror_char, exp_res.mirror_char);
					if (out_ch.number_ok !== exp_res.number_ok)
						report_mismatch("number_ok", out_ch.number_ok, exp_res.number_ok);
					if (out_ch.halted !== exp_res.halted)
						report_mismatch("halted", out_ch.halted, exp_res.halted);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(lex_and_mirror(in_ch.key_byte));
			outstanding = expected_results.size();
		end
	end

endmodule

>>> bench/tb_real_number_lexer_with_atbash_echo.sv
`timescale 1ns / 100ps
// Regression top: clock, reset, key byte stimulus, output back-pressure and the verdict.
module tb_real_number_lexer_with_atbash_echo;
	import rnl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 60;
	localparam int RANDOM_END  = 1530;
	localparam int QUIET_FROM  = 1450;
	localparam int HOLD_AT     = 500;

	logic       clk;
	logic       arst_n;
	logic       idle_on;
	logic       hold_req;
	logic       hold_done;
	logic       guard_on;
	// shadow of the escape capture, used to steer random text clear of a halt
	logic       esc_open;
	logic       esc_second;
	logic       esc_prev_open;
	logic [7:0] esc_lead;
	int         n_sent;
	int         idle_cycles = 0;
	int         mismatches;
	int         outstanding;

	rnl_in_if  in_ch();
	rnl_out_if out_ch();

	real_number_lexer_with_atbash_echo uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	rnl_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("real_number_lexer_with_atbash_echo regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: short random stalls, plus one long hold so the block backs up.
	initial begin
		int gap;
		gap = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (gap > 0) begin
				out_ch.ready <= 1'b0;
				gap--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(0, 2);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_key(input logic [7:0] raw);
		logic [7:0] b;
		int gap;
		b = raw;
		// while guarded, no escape nests inside a capture and no capture halts
		if (guard_on && esc_open && b == CH_ESC) b = 8'h1a;
		if (guard_on && esc_open && esc_second && esc_lead == CH_BRACKET && b == CH_HOME)
			b = 8'h49;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.key_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		n_sent++;
		if (b == CH_ESC) begin
			esc_second = 1'b0;
			esc_prev_open = esc_open;
			esc_open = 1'b1;
		end else if (esc_open) begin
			if (!esc_second) begin
				esc_lead = b;
				esc_second = 1'b1;
			end else begin
				esc_open = esc_prev_open;
			end
		end
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_sign();
		return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
	endfunction

	task automatic send_number();
		int n;
		if ($urandom_range(0, 1)) send_key(rand_sign());
		n = $urandom_range(1, 4);
		repeat (n) send_key(rand_digit());
		if ($urandom_range(0, 1)) begin
			send_key(CH_POINT);
			n = $urandom_range(1, 3);
			repeat (n) send_key(rand_digit());
		end
		if ($urandom_range(0, 2) == 0) begin
			send_key(CH_EXP);
			if ($urandom_range(0, 1)) send_key(rand_sign());
			n = $urandom_range(1, 2);
			repeat (n) send_key(rand_digit());
		end
	endtask

	task automatic send_word();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			send_key(8'(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + $urandom_range(0, 25)));
	endtask

	task automatic send_escape();
		send_key(CH_ESC);
		send_key($urandom_range(0, 2) == 0 ? CH_BRACKET : 8'($urandom_range(0, 255)));
		send_key($urandom_range(0, 2) == 0 ? CH_HOME : 8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) send_key(8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0] opening[$];
		logic [7:0] closing[$];
		int pick;
		// a valid signed number with escapes in it, then letters and odd bytes
		opening = '{CH_PLUS, CH_ZERO, CH_ESC, CH_BRACKET, CH_UC_Z, CH_NINE, CH_PLUS,
			CH_POINT, CH_ESC, 8'h00, 8'hff, 8'h37, CH_EXP, CH_MINUS, 8'h35, CH_ZERO,
			CH_LC_A, CH_LC_Z, CH_UC_A, CH_UC_Z, 8'h40, 8'h60, 8'h7b, 8'h80};
		// nested escape locks control mode; captures keep ending; then the halt
		closing = '{CH_ESC, CH_ESC, 8'h78, 8'h79, 8'h71, 8'h72, CH_ESC, CH_BRACKET,
			CH_HOME, CH_LC_A, 8'h37, CH_ESC, 8'hff};
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.key_byte = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		hold_done = 1'b0;
		guard_on = 1'b1;
		esc_open = 1'b0;
		esc_second = 1'b0;
		esc_prev_open = 1'b0;
		esc_lead = '0;
		n_sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) send_key(opening[i]);

		while (n_sent < RANDOM_END) begin
			if (n_sent >= QUIET_FROM) idle_on = 1'b0;
			else if ($urandom_range(0, 29) == 0) idle_on = $urandom_range(0, 3) != 0;
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick < 3) send_number();
			else if (pick < 6) send_word();
			else if (pick < 8) send_escape();
			else send_noise();
		end

		idle_on = 1'b0;
		guard_on = 1'b0;
		foreach (closing[i]) send_key(closing[i]);
		@(negedge clk);
		in_ch.valid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("%0d key bytes: valid number with escapes, letter echo, random text,", n_sent);
		$display("escapes and noise, a long output hold, nested escape and the frozen halt");
		if (mismatches == 0 && outstanding == 0) begin
			$display("real_number_lexer_with_atbash_echo regression: pass");
		end else begin
			$display("real_number_lexer_with_atbash_echo regression: fail");
		end
		$finish;
	end

endmodule
